@@ rtl/cbm_pkg.sv @@
package cbm_pkg;

   localparam int BANK_BITS = 4;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [2:0] {
      MODE_BOOT     = 3'd0,
      MODE_ALLFLASH = 3'd1,
      MODE_SROM     = 3'd2,
      MODE_ROMRAM   = 3'd3,
      MODE_RAM_A    = 3'd4,
      MODE_SRAM     = 3'd5,
      MODE_RAM_B    = 3'd6,
      MODE_OFF      = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      TGT_NONE  = 2'd0,
      TGT_RAM   = 2'd1,
      TGT_FLASH = 2'd2,
      TGT_REG   = 2'd3
   } target_type;

   typedef enum logic [1:0] {
      OB_DRIVEN = 2'd0,
      OB_CPU    = 2'd1,
      OB_VIDEO  = 2'd2
   } open_bus_type;

   localparam logic [1:0] REG_IDX_MODE    = 2'd2;
   localparam logic [1:0] REG_IDX_CONTROL = 2'd3;

   localparam logic [5:0] REG_WINDOW = 6'b100111;

   // physical address: bank in A18..A15, block base in A14..A13, inversion applied
   function automatic logic [18:0] phys_addr(input logic [12:0] offset,
                                             input logic [BANK_BITS-1:0] bank,
                                             input logic [1:0] base,
                                             input logic [7:0] control);
      logic [1:0] hi;
      hi = base ^ {control[6], control[5]};
      return {bank[3:0], hi, offset};
   endfunction

endpackage

@@ rtl/cartridge_bank_mapper_unit.sv @@
// an accepted request word is registered in the input stage, its response word in the output stage
// throughput: one request word per cycle while rsp_tready stays high; an input stage and an output stage
// let a new word enter while a finished response waits to be taken
// reset: synchronous, active high; mode and control registers clear to zero,
// start lock sets, both stages empty
module cartridge_bank_mapper_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cbm_pkg::REQ_DATA_W-1:0]    req_tdata,  // cpu_address[15:0], write_data[23:16]
   input  logic                              req_tuser,  // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cbm_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // mem_address[18:0], write_enable[19],
                                                         // reg_read_data[27:20], open_bus[29:28]
   output logic [1:0]                        rsp_tuser   // target
);

   logic        in_valid_ff;
   logic        kind_ff;
   logic [15:0] addr_ff;
   logic [7:0]  wdata_ff;

   logic        out_valid_ff;
   logic [1:0]  target_ff;
   logic [18:0] maddr_ff;
   logic        we_ff;
   logic [7:0]  rdata_ff;
   logic [1:0]  ob_ff;

   logic [7:0]  mode_reg_ff, mode_reg_in;
   logic [7:0]  control_ff, control_in;
   logic        lock_ff, lock_in;

   logic [1:0]  target_in;
   logic [18:0] maddr_in;
   logic        we_in;
   logic [7:0]  rdata_in;
   logic [1:0]  ob_in;

   logic        advance;
   logic        accept;

   cbm_pkg::mode_type             mode;
   logic [cbm_pkg::BANK_BITS-1:0] bankreg;
   logic [cbm_pkg::BANK_BITS-1:0] bank;
   logic [cbm_pkg::BANK_BITS-1:0] bank_one;
   logic [cbm_pkg::BANK_BITS-1:0] bank_two;
   logic [1:0]                    base;
   logic                          in_blk0, in_regs, in_blk;
   logic                          sel, dis, locked, ram0, ro0;
   logic [2:0]                    bit_idx;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign mode     = cbm_pkg::mode_type'(mode_reg_ff[7:5]);
   assign bankreg  = mode_reg_ff[cbm_pkg::BANK_BITS-1:0];
   assign bank_one = cbm_pkg::BANK_BITS'(1);
   assign bank_two = cbm_pkg::BANK_BITS'(2);

   assign in_blk0 = (addr_ff[15:12] == 4'h0) && (addr_ff[11:10] != 2'b00);
   assign in_regs = (addr_ff[15:10] == cbm_pkg::REG_WINDOW);

   always_comb begin
      in_blk  = 1'b1;
      base    = 2'd0;
      bit_idx = 3'd1;
      case (addr_ff[15:13])
         3'd1: begin base = 2'd0; bit_idx = 3'd1; end
         3'd2: begin base = 2'd1; bit_idx = 3'd2; end
         3'd3: begin base = 2'd2; bit_idx = 3'd3; end
         3'd5: begin base = 2'd3; bit_idx = 3'd4; end
         default: in_blk = 1'b0;
      endcase
   end

   assign sel    = mode_reg_ff[bit_idx];
   assign dis    = control_ff[bit_idx];
   assign locked = control_ff[7] || ((mode == cbm_pkg::MODE_BOOT) && lock_ff);
   assign ram0   = (mode inside {cbm_pkg::MODE_ROMRAM, cbm_pkg::MODE_RAM_A, cbm_pkg::MODE_RAM_B,
                                 cbm_pkg::MODE_SROM, cbm_pkg::MODE_SRAM});
   assign ro0    = mode_reg_ff[0] &&
                   (mode inside {cbm_pkg::MODE_ROMRAM, cbm_pkg::MODE_RAM_A, cbm_pkg::MODE_RAM_B});

   always_comb begin
      target_in   = cbm_pkg::TGT_NONE;
      maddr_in    = '0;
      we_in       = 1'b0;
      rdata_in    = '0;
      ob_in       = cbm_pkg::OB_DRIVEN;
      bank        = '0;
      mode_reg_in = mode_reg_ff;
      control_in  = control_ff;
      lock_in     = lock_ff;

      if (in_blk0) begin
         if (!control_ff[0]) begin
            if (!kind_ff) begin
               if (ram0) target_in = cbm_pkg::TGT_RAM;
               else ob_in = cbm_pkg::OB_CPU;
            end else if (ram0 && !ro0) begin
               target_in = cbm_pkg::TGT_RAM;
               we_in     = 1'b1;
            end
            if (target_in != cbm_pkg::TGT_NONE)
               maddr_in = cbm_pkg::phys_addr(addr_ff[12:0], '0, 2'd0, control_ff);
         end else if (!kind_ff) begin
            ob_in = cbm_pkg::OB_VIDEO;
         end
      end else if (in_regs) begin
         if (!locked && addr_ff[1]) begin
            target_in = cbm_pkg::TGT_REG;
            if (kind_ff) begin
               we_in = 1'b1;
               if (addr_ff[1:0] == cbm_pkg::REG_IDX_MODE) mode_reg_in = wdata_ff;
               else control_in = wdata_ff;
            end else begin
               rdata_in = (addr_ff[1:0] == cbm_pkg::REG_IDX_MODE) ? mode_reg_ff : control_ff;
            end
         end else if (!kind_ff) begin
            ob_in = cbm_pkg::OB_CPU;
         end
      end else if (in_blk) begin
         if (base == 2'd3) lock_in = !kind_ff;
         if (dis) begin
            if (!kind_ff) ob_in = cbm_pkg::OB_CPU;
         end else if (!kind_ff) begin
            case (mode)
               cbm_pkg::MODE_ALLFLASH, cbm_pkg::MODE_SROM, cbm_pkg::MODE_SRAM: bank = bankreg;
               cbm_pkg::MODE_ROMRAM, cbm_pkg::MODE_RAM_A: bank = bank_one;
               cbm_pkg::MODE_RAM_B: bank = sel ? bank_two : bank_one;
               default: bank = '0;
            endcase
            case (mode)
               cbm_pkg::MODE_BOOT:
                  if (base == 2'd3) target_in = cbm_pkg::TGT_FLASH;
               cbm_pkg::MODE_ALLFLASH, cbm_pkg::MODE_SROM: target_in = cbm_pkg::TGT_FLASH;
               cbm_pkg::MODE_ROMRAM: target_in = sel ? cbm_pkg::TGT_FLASH : cbm_pkg::TGT_RAM;
               cbm_pkg::MODE_RAM_A, cbm_pkg::MODE_RAM_B, cbm_pkg::MODE_SRAM:
                  target_in = cbm_pkg::TGT_RAM;
               default: target_in = cbm_pkg::TGT_NONE;
            endcase
            if (target_in == cbm_pkg::TGT_NONE) ob_in = cbm_pkg::OB_CPU;
         end else begin
            case (mode)
               cbm_pkg::MODE_ALLFLASH, cbm_pkg::MODE_SRAM: bank = bankreg;
               cbm_pkg::MODE_SROM: bank = bank_one | bankreg;
               cbm_pkg::MODE_BOOT, cbm_pkg::MODE_RAM_B: bank = bank_one;
               cbm_pkg::MODE_ROMRAM, cbm_pkg::MODE_RAM_A: bank = sel ? bank_two : bank_one;
               default: bank = '0;
            endcase
            case (mode)
               cbm_pkg::MODE_ALLFLASH: target_in = cbm_pkg::TGT_FLASH;
               cbm_pkg::MODE_ROMRAM: target_in = sel ? cbm_pkg::TGT_RAM : cbm_pkg::TGT_NONE;
               cbm_pkg::MODE_BOOT, cbm_pkg::MODE_RAM_A, cbm_pkg::MODE_RAM_B,
               cbm_pkg::MODE_SROM, cbm_pkg::MODE_SRAM: target_in = cbm_pkg::TGT_RAM;
               default: target_in = cbm_pkg::TGT_NONE;
            endcase
            we_in = (target_in != cbm_pkg::TGT_NONE);
         end
         if (target_in != cbm_pkg::TGT_NONE)
            maddr_in = cbm_pkg::phys_addr(addr_ff[12:0], bank, base, control_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_reg_ff  <= '0;
         control_ff   <= '0;
         lock_ff      <= 1'b1;
      end else begin
         if (accept) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
         if (advance) begin
            mode_reg_ff <= mode_reg_in;
            control_ff  <= control_in;
            lock_ff     <= lock_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_tuser;
         addr_ff  <= req_tdata[15:0];
         wdata_ff <= req_tdata[23:16];
      end
      if (advance) begin
         target_ff <= target_in;
         maddr_ff  <= maddr_in;
         we_ff     <= we_in;
         rdata_ff  <= rdata_in;
         ob_ff     <= ob_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = target_ff;
   assign rsp_tdata  = {2'b00, ob_ff, rdata_ff, we_ff, maddr_ff};

endmodule

@@ rtl/cbm_checker.sv @@
module cbm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cbm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                     rsp_tuser
);

   // no device answers: no address, no write, no register data
   a_none_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == cbm_pkg::TGT_NONE) |->
         (rsp_tdata[19:0] == 20'd0 && rsp_tdata[27:20] == 8'd0))
      else $error("idle target carries payload");

   // writes never leave the bus open
   a_write_driven: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[19]) |->
         (rsp_tdata[29:28] == cbm_pkg::OB_DRIVEN && rsp_tuser != cbm_pkg::TGT_NONE))
      else $error("write word with open bus or no target");

   // register data only on register reads
   a_rdata_reg: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[27:20] != 8'd0) |->
         (rsp_tuser == cbm_pkg::TGT_REG && !rsp_tdata[19]))
      else $error("register data outside register read");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("response after reset");

endmodule

bind cartridge_bank_mapper_unit cbm_checker u_cbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   localparam int   LIMIT        = 400000;
   localparam int   RANDOM_ITEMS = 1600;
   localparam logic KIND_READ    = 1'b0;
   localparam logic KIND_WRITE   = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] addr;
      logic [7:0]  data;
   } bus_access_type;

   typedef struct packed {
      cbm_pkg::target_type   target;
      logic [18:0]           mem_address;
      logic                  write_enable;
      logic [7:0]            reg_data;
      cbm_pkg::open_bus_type open_bus;
   } access_outcome_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [cbm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [cbm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;

   bus_access_type     access_queue[$];
   access_outcome_type outcome_fifo[$];

   // mapper state as seen by the predictor
   logic [7:0] mode_reg   = 8'h00;
   logic [7:0] ctrl_reg   = 8'h00;
   logic       start_lock = 1'b1;

   int cycles      = 0;
   int fault_count = 0;
   int word_count  = 0;
   int target_hits[4] = '{0, 0, 0, 0};
   int req_wait    = 0;
   int rsp_stall   = 0;
   bit req_taken   = 1'b0;
   bit rsp_taken   = 1'b0;
   bit calm        = 1'b0;

   cartridge_bank_mapper_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic logic [18:0] bus_to_phys(logic [15:0] addr,
                                                logic [cbm_pkg::BANK_BITS-1:0] bank,
                                                logic [1:0] base_hi);
      logic [18:0] a;
      a = {bank, base_hi, addr[12:0]};
      a[13] = a[13] ^ ctrl_reg[5];
      a[14] = a[14] ^ ctrl_reg[6];
      return a;
   endfunction

   function automatic access_outcome_type map_access(bus_access_type acc);
      access_outcome_type            o;
      cbm_pkg::mode_type             m;
      logic [cbm_pkg::BANK_BITS-1:0] bank;
      logic [cbm_pkg::BANK_BITS-1:0] bank_field;
      logic [1:0]                    base_hi;
      int                            bidx;
      logic                          wr, sel, ram_mode, read_only, locked;
      o.target       = cbm_pkg::TGT_NONE;
      o.mem_address  = '0;
      o.write_enable = 1'b0;
      o.reg_data     = 8'h00;
      o.open_bus     = cbm_pkg::OB_DRIVEN;
      wr         = acc.kind == KIND_WRITE;
      m          = cbm_pkg::mode_type'(mode_reg[7:5]);
      bank_field = mode_reg[cbm_pkg::BANK_BITS-1:0];
      bank       = '0;
      base_hi    = 2'd0;
      bidx       = 0;
      if (acc.addr >= 16'h0400 && acc.addr <= 16'h0fff) begin
         if (!ctrl_reg[0]) begin
            ram_mode  = m == cbm_pkg::MODE_ROMRAM || m == cbm_pkg::MODE_RAM_A ||
                        m == cbm_pkg::MODE_RAM_B || m == cbm_pkg::MODE_SROM ||
                        m == cbm_pkg::MODE_SRAM;
            read_only = mode_reg[0] && (m == cbm_pkg::MODE_ROMRAM || m == cbm_pkg::MODE_RAM_A ||
                                        m == cbm_pkg::MODE_RAM_B);
            if (!wr) begin
               if (ram_mode) o.target = cbm_pkg::TGT_RAM;
               else o.open_bus = cbm_pkg::OB_CPU;
            end else if (ram_mode && !read_only) begin
               o.target       = cbm_pkg::TGT_RAM;
               o.write_enable = 1'b1;
            end
            if (o.target != cbm_pkg::TGT_NONE) o.mem_address = bus_to_phys(acc.addr, '0, 2'd0);
         end else if (!wr) begin
            o.open_bus = cbm_pkg::OB_VIDEO;
         end
      end else if (acc.addr >= 16'h9c00 && acc.addr <= 16'h9fff) begin
         locked = ctrl_reg[7] || (m == cbm_pkg::MODE_BOOT && start_lock);
         if (!locked && acc.addr[1:0] >= cbm_pkg::REG_IDX_MODE) begin
            o.target = cbm_pkg::TGT_REG;
            if (wr) begin
               o.write_enable = 1'b1;
               if (acc.addr[1:0] == cbm_pkg::REG_IDX_MODE) mode_reg = acc.data;
               else ctrl_reg = acc.data;
            end else begin
               o.reg_data = (acc.addr[1:0] == cbm_pkg::REG_IDX_MODE) ? mode_reg : ctrl_reg;
            end
         end else if (!wr) begin
            o.open_bus = cbm_pkg::OB_CPU;
         end
      end else begin
         case (acc.addr[15:13])
            3'd1: begin bidx = 1; base_hi = 2'd0; end
            3'd2: begin bidx = 2; base_hi = 2'd1; end
            3'd3: begin bidx = 3; base_hi = 2'd2; end
            3'd5: begin bidx = 4; base_hi = 2'd3; end
            default: bidx = 0;
         endcase
         if (bidx != 0) begin
            sel = mode_reg[bidx];
            // block 5 reads lock the registers again, writes release them
            if (bidx == 4) start_lock = !wr;
            if (ctrl_reg[bidx]) begin
               if (!wr) o.open_bus = cbm_pkg::OB_CPU;
            end else if (!wr) begin
               case (m)
                  cbm_pkg::MODE_ALLFLASH, cbm_pkg::MODE_SROM, cbm_pkg::MODE_SRAM:
                     bank = bank_field;
                  cbm_pkg::MODE_ROMRAM, cbm_pkg::MODE_RAM_A: bank = cbm_pkg::BANK_BITS'(1);
                  cbm_pkg::MODE_RAM_B:
                     bank = sel ? cbm_pkg::BANK_BITS'(2) : cbm_pkg::BANK_BITS'(1);
                  default: bank = '0;
               endcase
               case (m)
                  cbm_pkg::MODE_BOOT: if (bidx == 4) o.target = cbm_pkg::TGT_FLASH;
                  cbm_pkg::MODE_ALLFLASH, cbm_pkg::MODE_SROM: o.target = cbm_pkg::TGT_FLASH;
                  cbm_pkg::MODE_ROMRAM:
                     o.target = sel ? cbm_pkg::TGT_FLASH : cbm_pkg::TGT_RAM;
                  cbm_pkg::MODE_RAM_A, cbm_pkg::MODE_RAM_B, cbm_pkg::MODE_SRAM:
                     o.target = cbm_pkg::TGT_RAM;
                  default: o.target = cbm_pkg::TGT_NONE;
               endcase
               if (o.target == cbm_pkg::TGT_NONE) o.open_bus = cbm_pkg::OB_CPU;
            end else begin
               case (m)
                  cbm_pkg::MODE_ALLFLASH, cbm_pkg::MODE_SRAM: bank = bank_field;
                  // super rom writes always set bank bit 0
                  cbm_pkg::MODE_SROM: bank = {bank_field[cbm_pkg::BANK_BITS-1:1], 1'b1};
                  cbm_pkg::MODE_BOOT, cbm_pkg::MODE_RAM_B: bank = cbm_pkg::BANK_BITS'(1);
                  cbm_pkg::MODE_ROMRAM, cbm_pkg::MODE_RAM_A:
                     bank = sel ? cbm_pkg::BANK_BITS'(2) : cbm_pkg::BANK_BITS'(1);
                  default: bank = '0;
               endcase
               case (m)
                  cbm_pkg::MODE_ALLFLASH: o.target = cbm_pkg::TGT_FLASH;
                  cbm_pkg::MODE_ROMRAM: o.target = sel ? cbm_pkg::TGT_RAM : cbm_pkg::TGT_NONE;
                  cbm_pkg::MODE_BOOT, cbm_pkg::MODE_RAM_A, cbm_pkg::MODE_RAM_B,
                  cbm_pkg::MODE_SROM, cbm_pkg::MODE_SRAM: o.target = cbm_pkg::TGT_RAM;
                  default: o.target = cbm_pkg::TGT_NONE;
               endcase
               o.write_enable = o.target != cbm_pkg::TGT_NONE;
            end
            if (o.target != cbm_pkg::TGT_NONE)
               o.mem_address = bus_to_phys(acc.addr, bank, base_hi);
         end
      end
      return o;
   endfunction

   task automatic note_fault(string what, access_outcome_type want, access_outcome_type got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t %s: expected tgt=%0d addr=%05h we=%0d rd=%02h ob=%0d", $realtime, what,
                  want.target, want.mem_address, want.write_enable, want.reg_data,
                  want.open_bus);
         $display("%0t %s:   actual tgt=%0d addr=%05h we=%0d rd=%02h ob=%0d", $realtime, what,
                  got.target, got.mem_address, got.write_enable, got.reg_data, got.open_bus);
      end
   endtask

   task automatic add_access(logic kind, logic [15:0] addr, logic [7:0] data);
      bus_access_type a;
      a.kind = kind;
      a.addr = addr;
      a.data = data;
      access_queue.push_back(a);
   endtask

   function automatic logic [15:0] reg_address(logic [1:0] idx);
      logic [7:0] alias_bits;
      alias_bits = 8'($urandom);
      return {cbm_pkg::REG_WINDOW, alias_bits, idx};
   endfunction

   task automatic add_random_access(bit allow_hide);
      logic        kind;
      logic [15:0] addr;
      logic [15:0] offset;
      logic [7:0]  data;
      int          pick;
      kind = 1'($urandom_range(0, 1));
      data = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         addr = 16'($urandom_range(16'h0400, 16'h0fff));
      end else if (pick < 65) begin
         case ($urandom_range(0, 3))
            0: addr = 16'h2000;
            1: addr = 16'h4000;
            2: addr = 16'h6000;
            default: addr = 16'ha000;
         endcase
         if ($urandom_range(0, 9) == 0) offset = $urandom_range(0, 1) ? 16'h1fff : 16'h0000;
         else offset = 16'($urandom_range(0, 16'h1fff));
         addr = addr + offset;
      end else if (pick < 80) begin
         addr = reg_address(2'($urandom_range(0, 3)));
         // keep the registers reachable until the last phase
         if (kind == KIND_WRITE && addr[1:0] == cbm_pkg::REG_IDX_CONTROL && !allow_hide)
            data[7] = 1'b0;
      end else begin
         case ($urandom_range(0, 3))
            0: addr = 16'($urandom_range(16'h0000, 16'h03ff));
            1: addr = 16'($urandom_range(16'h1000, 16'h1fff));
            2: addr = 16'($urandom_range(16'h8000, 16'h9bff));
            default: addr = 16'($urandom_range(16'hc000, 16'hffff));
         endcase
      end
      add_access(kind, addr, data);
   endtask

   task automatic set_mapping(logic [7:0] mode_val, logic [7:0] ctrl_val);
      logic [15:0] unlock_addr;
      unlock_addr = 16'ha000 + 16'($urandom_range(0, 16'h1fff));
      add_access(KIND_WRITE, unlock_addr, 8'($urandom));
      add_access(KIND_WRITE, reg_address(cbm_pkg::REG_IDX_MODE), mode_val);
      add_access(KIND_WRITE, reg_address(cbm_pkg::REG_IDX_CONTROL), ctrl_val);
      add_access(KIND_READ, reg_address(cbm_pkg::REG_IDX_MODE), 8'($urandom));
      add_access(KIND_READ, reg_address(cbm_pkg::REG_IDX_CONTROL), 8'($urandom));
   endtask

   // request driver
   always @(negedge clock) begin
      bus_access_type cur;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = draw_gap();
      end else if (!req_tvalid || req_taken) begin
         if (req_wait > 0 || access_queue.size() == 0) begin
            if (req_wait > 0) req_wait--;
            req_tvalid <= 1'b0;
         end else begin
            cur = access_queue.pop_front();
            req_tdata  <= {cur.data, cur.addr};
            req_tuser  <= cur.kind;
            req_tvalid <= 1'b1;
            req_wait = draw_gap();
         end
      end
      req_taken = 1'b0;
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) rsp_stall = draw_gap();
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
      rsp_taken = 1'b0;
   end

   // monitor and checker
   always @(posedge clock) begin
      access_outcome_type got, want;
      bus_access_type     acc;
      cycles++;
      if (cycles % 200 == 0) calm = $urandom_range(0, 3) == 0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            acc.kind = req_tuser;
            acc.addr = req_tdata[15:0];
            acc.data = req_tdata[23:16];
            outcome_fifo.push_back(map_access(acc));
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken        = 1'b1;
            got.target       = cbm_pkg::target_type'(rsp_tuser);
            got.mem_address  = rsp_tdata[18:0];
            got.write_enable = rsp_tdata[19];
            got.reg_data     = rsp_tdata[27:20];
            got.open_bus     = cbm_pkg::open_bus_type'(rsp_tdata[29:28]);
            if (outcome_fifo.size() == 0) begin
               want = '0;
               note_fault("unexpected word", want, got);
            end else begin
               want = outcome_fifo.pop_front();
               word_count++;
               target_hits[want.target]++;
               if (got.target !== want.target || got.mem_address !== want.mem_address ||
                   got.write_enable !== want.write_enable || got.reg_data !== want.reg_data ||
                   got.open_bus !== want.open_bus)
                  note_fault("mismatch", want, got);
            end
         end
      end
      if (cycles >= LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int         n;
      int         phase_items;
      logic [7:0] mode_val;
      logic [7:0] ctrl_val;

      // directed: lock, modes, block-0 read-only, super rom bank, disables
      add_access(KIND_READ, 16'h9c02, 8'h00);
      add_access(KIND_READ, 16'h0000, 8'h00);
      add_access(KIND_WRITE, 16'hffff, 8'hff);
      add_access(KIND_READ, 16'h0400, 8'h00);
      add_access(KIND_READ, 16'ha000, 8'h00);
      add_access(KIND_WRITE, 16'h9c02, 8'h4f);
      add_access(KIND_WRITE, 16'hbfff, 8'h5a);
      add_access(KIND_WRITE, 16'h9c03, 8'h60);
      add_access(KIND_READ, 16'h9fff, 8'h00);
      add_access(KIND_WRITE, 16'h9c02, 8'h4f);
      add_access(KIND_WRITE, 16'h2000, 8'ha5);
      add_access(KIND_READ, 16'h7fff, 8'h00);
      add_access(KIND_WRITE, 16'h9c02, 8'h71);
      add_access(KIND_WRITE, 16'h0400, 8'h00);
      add_access(KIND_WRITE, 16'h6000, 8'h11);
      add_access(KIND_WRITE, 16'ha123, 8'h22);
      add_access(KIND_READ, 16'h4abc, 8'h00);
      add_access(KIND_WRITE, 16'h9c03, 8'h1f);
      add_access(KIND_READ, 16'h0fff, 8'h00);
      add_access(KIND_READ, 16'h5000, 8'h00);
      add_access(KIND_WRITE, 16'hb000, 8'h33);
      add_access(KIND_READ, 16'h9c00, 8'h00);
      add_access(KIND_WRITE, 16'h9c01, 8'hff);
      add_access(KIND_WRITE, 16'h9c02, 8'he0);
      add_access(KIND_WRITE, 16'h9c03, 8'h00);
      add_access(KIND_READ, 16'h3000, 8'h00);
      add_access(KIND_WRITE, 16'h0800, 8'h44);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         mode_val = 8'($urandom);
         if ($urandom_range(0, 1)) ctrl_val = 8'($urandom) & 8'h7f;
         else ctrl_val = 8'($urandom) & 8'h60;
         set_mapping(mode_val, ctrl_val);
         phase_items = $urandom_range(20, 60);
         repeat (phase_items) add_random_access(1'b0);
         n += phase_items + 5;
      end
      // last phase hides the registers for good
      set_mapping(8'($urandom), 8'h80 | (8'($urandom) & 8'h60));
      repeat (40) add_random_access(1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (access_queue.size() != 0 || req_tvalid || outcome_fifo.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d response words, %0d faults", word_count, fault_count);
      $display("targets seen: none %0d, ram %0d, flash %0d, register %0d",
               target_hits[cbm_pkg::TGT_NONE], target_hits[cbm_pkg::TGT_RAM],
               target_hits[cbm_pkg::TGT_FLASH], target_hits[cbm_pkg::TGT_REG]);
      if (fault_count == 0 && outcome_fifo.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
